// ----- rtl/itad_pkg.sv -----
// Shared types, codes and a helper function for the integer to ASCII digit converter.
`default_nettype none

package itad_pkg;

  // Format codes carried in the input item's tuser field.
  typedef enum logic [1:0] {
    REQ_DEC  = 2'd0,
    REQ_OCT  = 2'd1,
    REQ_HEXL = 2'd2,
    REQ_HEXU = 2'd3
  } req_t;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned DecWidth   = 32;
  localparam int unsigned CharWidth  = 8;

  // Working word: 22 octal digits of three bits each.
  localparam int unsigned WorkWidth  = 66;
  localparam int unsigned BcdDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * BcdDigits;

  localparam logic [4:0] OctDigits   = 5'd22;
  localparam logic [4:0] HexDigits   = 5'd16;
  localparam logic [4:0] DecDigits   = 5'd10;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2d;
  localparam logic [CharWidth-1:0] LowerBase = 8'd87;
  localparam logic [CharWidth-1:0] UpperBase = 8'd55;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    req_t                  kind;
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } entry_t;

  // ASCII code of one digit value in the given format.
  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] d, input req_t kind);
    logic [CharWidth-1:0] dd;
    dd = {4'd0, d};
    if (d <= 4'd9) begin
      digit_char = dd + CharZero;
    end else if (kind == REQ_HEXU) begin
      digit_char = dd + UpperBase;
    end else begin
      digit_char = dd + LowerBase;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itad_front.sv -----
// Front end: accepts input items, takes the decimal sign apart and forms the magnitude.
`default_nettype none

module itad_front (
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [63:0]                   s_tdata,   // value[63:0]
  input  wire logic [1:0]                    s_tuser,   // req_type[1:0]
  input  wire logic                          q_full,
  output logic                               q_push,
  output itad_pkg::entry_t                   q_entry
);
  import itad_pkg::*;

  logic [DecWidth-1:0] low_word;

  assign low_word = s_tdata[DecWidth-1:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Classify the item; a negative decimal value is stored as its unsigned magnitude.
  always_comb begin
    q_entry.kind = req_t'(s_tuser);
    q_entry.neg  = 1'b0;
    q_entry.mag  = s_tdata;
    if (req_t'(s_tuser) == REQ_DEC) begin
      q_entry.neg = low_word[DecWidth-1];
      if (low_word[DecWidth-1]) begin
        q_entry.mag = {{(ValueWidth-DecWidth){1'b0}}, (~low_word) + 32'd1};
      end else begin
        q_entry.mag = {{(ValueWidth-DecWidth){1'b0}}, low_word};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itad_queue.sv -----
// Short register queue that decouples the front end from the digit engine.
`default_nettype none

module itad_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire itad_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output itad_pkg::entry_t       head
);
  import itad_pkg::*;

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

  entry_t              slots [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage is written at the write pointer only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Fill count stays within depth, a lone push raises it, and an empty queue is never popped.
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("queue fill count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from an empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
      (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("push did not raise the fill count");

endmodule

`default_nettype wire

// ----- rtl/itad_back.sv -----
// Digit engine: bit-serial decimal conversion, leading zero skip and character output.
`default_nettype none

module itad_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire itad_pkg::entry_t  q_head,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,   // char_out[7:0]
  output logic                   m_tlast    // last_char
);
  import itad_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_SKIP = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                 state;
  req_t                   kind;
  logic                   neg;
  logic [WorkWidth-1:0]   wr;
  logic [BcdWidth-1:0]    bcd;
  logic [BcdWidth-1:0]    bcd_adj;
  logic [4:0]             cnt;
  logic [4:0]             dcnt;
  logic [3:0]             top;
  logic [WorkWidth-1:0]   wr_shift;
  logic                   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // Leading digit and the word after it has been consumed.
  always_comb begin
    if (kind == REQ_OCT) begin
      top      = {1'b0, wr[WorkWidth-1 -: 3]};
      wr_shift = wr << 3;
    end else begin
      top      = wr[ValueWidth-1 -: 4];
      wr_shift = wr << 4;
    end
  end

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            kind <= q_head.kind;
            neg  <= q_head.neg;
            if (q_head.kind == REQ_DEC) begin
              wr    <= {{(WorkWidth-DecWidth){1'b0}}, q_head.mag[DecWidth-1:0]};
              bcd   <= '0;
              cnt   <= '0;
              state <= ST_CONV;
            end else begin
              wr    <= {{(WorkWidth-ValueWidth){1'b0}}, q_head.mag};
              dcnt  <= (q_head.kind == REQ_OCT) ? OctDigits : HexDigits;
              state <= ST_SIGN;
            end
          end
        end
        ST_CONV: begin
          bcd <= {bcd_adj[BcdWidth-2:0], wr[DecWidth-1]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            // Left-justify the BCD result where the hex digits sit.
            wr    <= {{(WorkWidth-ValueWidth){1'b0}}, bcd_adj[BcdWidth-2:0], wr[DecWidth-1],
                      {(ValueWidth-BcdWidth){1'b0}}};
            dcnt  <= DecDigits;
            state <= ST_SIGN;
          end else begin
            wr <= {{(WorkWidth-DecWidth){1'b0}}, wr[DecWidth-2:0], 1'b0};
          end
        end
        ST_SIGN: begin
          if (!neg || out_free) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top == 4'd0 && dcnt > 5'd1) begin
            wr   <= wr_shift;
            dcnt <= dcnt - 5'd1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            wr   <= wr_shift;
            dcnt <= dcnt - 5'd1;
            if (dcnt == 5'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register; a new item is loaded whenever the previous one is gone or taken now.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      if (state == ST_SIGN && neg) begin
        m_tvalid <= 1'b1;
        m_tdata  <= CharMinus;
        m_tlast  <= 1'b0;
      end else if (state == ST_EMIT) begin
        m_tvalid <= 1'b1;
        m_tdata  <= digit_char(top, kind);
        m_tlast  <= (dcnt == 5'd1);
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Digits never run out while characters are being sent.
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EMIT || state == ST_SKIP) |-> dcnt != 5'd0)
    else $error("digit count exhausted during output");
  // A minus sign only ever precedes a decimal number.
  a_neg_dec: assert property (@(posedge clk) disable iff (rst)
      (state == ST_SIGN && neg) |-> kind == REQ_DEC)
    else $error("sign on a non-decimal item");
  // Every emitted digit of a decimal number is a valid BCD digit.
  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
      (state == ST_EMIT && kind == REQ_DEC) |-> top <= 4'd9)
    else $error("decimal digit out of range");

endmodule

`default_nettype wire

// ----- rtl/integer_to_ascii_digits.sv -----
// Top level of the integer to ASCII digit converter: front end, queue and digit engine.
// Order per item: decimal values first run 32 double-dabble steps, then a minus sign is
//   registered for a negative decimal, leading zeros are skipped, and the digits follow.
//   Throughput: one character per cycle once the digits start, while m_tready holds; the
//   single digit engine takes the next item only after the last character of the current one.
// Synchronous active-high rst empties the queue and the output register.
`default_nettype none

module integer_to_ascii_digits #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // value[63:0]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // char_out[7:0]
  output logic             m_tlast    // last_char
);
  import itad_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   full;
  logic   pop;
  logic   not_empty;

  itad_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (full),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  itad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  itad_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_head   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
